/* rtl/sensor_uart_command_engine_top_defines.svh */
// Assertion macros shared by the RTL of the sensor command engine.
// Included by modules that carry concurrent assertions.
`ifndef SENSOR_UART_COMMAND_ENGINE_TOP_DEFINES_SVH
`define SENSOR_UART_COMMAND_ENGINE_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SUCE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define SUCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* rtl/suce_pkg.sv */
// Package for the sensor command engine: opcodes, lengths, codes, queue item type.
// No dependencies.
`timescale 1ns / 1ps
package suce_pkg;
   localparam int MaxResponseBytes = 16;
   localparam int BufIdxW = $clog2(MaxResponseBytes);

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_RX    = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam logic [2:0] CMD_GET_PRESS = 3'd0;
   localparam logic [2:0] CMD_SET_PRESS = 3'd1;
   localparam logic [2:0] CMD_GET_GAS   = 3'd2;
   localparam logic [2:0] CMD_OPEN_CAL  = 3'd3;
   localparam logic [2:0] CMD_CLOSE_CAL = 3'd4;
   localparam logic [2:0] CMD_CAL_STAT  = 3'd5;
   localparam logic [2:0] CMD_GET_HOURS = 3'd6;
   localparam logic [2:0] CMD_SET_HOURS = 3'd7;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_CHECKSUM = 3'd1;
   localparam logic [2:0] ERR_PRESSURE = 3'd2;
   localparam logic [2:0] ERR_GAS_STAT = 3'd3;
   localparam logic [2:0] ERR_FAILED   = 3'd4;
   localparam logic [2:0] ERR_ARGUMENT = 3'd5;

   localparam logic [1:0] CSR_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_SUPPRESS = 2'd2;

   // Job kinds handed from the front end to the back end.
   localparam logic [1:0] JOB_FRAME = 2'd0; // emit a command frame
   localparam logic [1:0] JOB_DONE  = 2'd1; // emit one completion result

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  command;
      logic [15:0] argument;
      logic        ok;
      logic [31:0] value;
      logic [2:0]  error_code;
   } job_type;

   function automatic logic [7:0] opcode_of(input logic [2:0] c);
      logic [7:0] r;
      unique case (c)
         CMD_GET_PRESS: r = 8'h02;
         CMD_SET_PRESS: r = 8'h01;
         CMD_GET_GAS:   r = 8'h03;
         CMD_OPEN_CAL:  r = 8'h06;
         CMD_CLOSE_CAL: r = 8'h06;
         CMD_CAL_STAT:  r = 8'h07;
         CMD_GET_HOURS: r = 8'h08;
         default:       r = 8'h09;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] dlen_of(input logic [2:0] c);
      logic [1:0] r;
      unique case (c)
         CMD_SET_PRESS, CMD_SET_HOURS: r = 2'd2;
         CMD_OPEN_CAL, CMD_CLOSE_CAL:  r = 2'd1;
         default:                      r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] rlen_of(input logic [2:0] c);
      logic [4:0] r;
      unique case (c)
         CMD_GET_GAS:                 r = 5'd14;
         CMD_OPEN_CAL, CMD_CLOSE_CAL: r = 5'd9;
         CMD_CAL_STAT, CMD_SET_HOURS: r = 5'd10;
         default:                     r = 5'd11;
      endcase
      return r;
   endfunction
endpackage

/* rtl/sensor_uart_command_engine_top.sv */
// Top level of the sensor command engine: config registers, front end, queue, back end.
// Depends on suce_pkg, suce_front, suce_queue and suce_back.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | type, command, argument, rx_byte
//   rsp     | out       | rsp_valid/rsp_stall | tx byte or completion fields
//   csr     | in        | csr_write           | index, 16-bit data
//
// An item is taken while the two-entry job queue has room; the front end
// decides it completely in the same cycle. A start emits 9 to 11 frame
// bytes, one per cycle from the back end while rsp is not stalled, so the
// rate is set by the back end's byte sequencer. Reset is synchronous and
// clears all control state; the reply buffer is not cleared. A stall on rsp
// holds the output register and fills the queue, which then stalls req.
`timescale 1ns / 1ps
module sensor_uart_command_engine_top
   import suce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_argument,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_done_res,
   output logic        rsp_ok,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic [15:0] timeout_ff, interval_ff;
   logic        suppress_ff;
   logic        job_valid, q_full, q_ready, q_pop;
   job_type     job_front, job_head;

   // Configuration registers; writes to unused indexes drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 16'd100;
         interval_ff <= 16'd2000;
         suppress_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TIMEOUT:  timeout_ff <= csr_data;
            CSR_INTERVAL: interval_ff <= csr_data;
            CSR_SUPPRESS: suppress_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   suce_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_command(req_command),
      .req_argument(req_argument), .req_rx_byte(req_rx_byte),
      .timeout_ticks(timeout_ff), .read_interval_ticks(interval_ff),
      .suppress_errors(suppress_ff),
      .job_valid(job_valid), .job(job_front), .job_full(q_full)
   );

   suce_queue u_queue (
      .clock(clock), .reset(reset),
      .push(job_valid), .push_job(job_front), .full(q_full),
      .not_empty(q_ready), .head(job_head), .pop(q_pop)
   );

   suce_back u_back (
      .clock(clock), .reset(reset),
      .job_ready(q_ready), .job(job_head), .job_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_tx_valid(rsp_tx_valid), .rsp_tx_byte(rsp_tx_byte),
      .rsp_last_of_run(rsp_last_of_run), .rsp_done_res(rsp_done_res),
      .rsp_ok(rsp_ok), .rsp_value(rsp_value), .rsp_error_code(rsp_error_code)
   );
endmodule

/* rtl/suce_front.sv */
// Front end: accepts items, runs the transaction, decodes replies into jobs.
// Depends on suce_pkg.
`timescale 1ns / 1ps
module suce_front
   import suce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_argument,
   input  logic [7:0]  req_rx_byte,
   input  logic [15:0] timeout_ticks,
   input  logic [15:0] read_interval_ticks,
   input  logic        suppress_errors,
   output logic        job_valid,
   output job_type     job,
   input  logic        job_full
);
   logic        busy_ff, busy_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] wait_ff, wait_in;
   logic [15:0] gas_age_ff, gas_age_in;
   logic [31:0] held_gas_ff, held_gas_in;
   logic [15:0] held_press_ff, held_press_in;
   logic [7:0]  buf_ff [MaxResponseBytes];

   logic        acc;
   logic [4:0]  rlen, cnt_next;
   logic [15:0] expect_sum;
   logic [16:0] wait_next;
   logic        bad_arg;
   logic [2:0]  err;
   logic        fail;

   assign req_stall = job_full;
   assign acc = req_valid && !job_full;
   assign rlen = rlen_of(cmd_ff);
   assign cnt_next = cnt_ff + 5'd1;
   assign wait_next = {1'b0, wait_ff} + 17'd1;
   // Trailing checksum bytes; the last one is the byte arriving now.
   assign expect_sum = {buf_ff[BufIdxW'(rlen - 5'd2)], req_rx_byte};

   function automatic logic [31:0] fail_value(input logic [2:0] c, input logic [2:0] e,
                                             input logic s, input logic [15:0] hp,
                                             input logic [31:0] hg);
      logic [31:0] r;
      if (!s) r = {29'd0, e};
      else if (c == CMD_GET_PRESS) r = {16'd0, hp};
      else if (c == CMD_GET_GAS) r = hg;
      else r = '0;
      return r;
   endfunction

   always_comb begin
      busy_in = busy_ff;
      cmd_in = cmd_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      wait_in = wait_ff;
      gas_age_in = gas_age_ff;
      held_gas_in = held_gas_ff;
      held_press_in = held_press_ff;
      job_valid = 1'b0;
      job = '0;
      job.command = req_command;
      job.argument = req_argument;
      bad_arg = 1'b0;
      err = ERR_NONE;
      fail = 1'b0;
      if (acc) begin
         unique case (req_type)
            REQ_START: begin
               if (!busy_ff) begin
                  bad_arg = (req_command == CMD_SET_PRESS &&
                             (req_argument < 16'd700 || req_argument > 16'd1100)) ||
                            (req_command == CMD_SET_HOURS &&
                             (req_argument < 16'd24 || req_argument > 16'd720));
                  job_valid = 1'b1;
                  job.kind = JOB_DONE;
                  if (bad_arg) begin
                     job.error_code = ERR_ARGUMENT;
                     job.value = fail_value(req_command, ERR_ARGUMENT, suppress_errors,
                                            held_press_ff, held_gas_ff);
                  end else if (req_command == CMD_GET_GAS &&
                               gas_age_ff < read_interval_ticks) begin
                     job.ok = 1'b1;
                     job.value = held_gas_ff;
                  end else begin
                     job.kind = JOB_FRAME;
                     if (req_command == CMD_GET_GAS) gas_age_in = '0;
                     busy_in = 1'b1;
                     cmd_in = req_command;
                     cnt_in = '0;
                     sum_in = '0;
                     wait_in = '0;
                  end
               end
            end
            REQ_RX: begin
               if (busy_ff) begin
                  cnt_in = cnt_next;
                  if (cnt_ff + 5'd2 < rlen) sum_in = sum_ff + 16'(req_rx_byte);
                  if (cnt_next >= rlen) begin
                     busy_in = 1'b0;
                     job_valid = 1'b1;
                     job.kind = JOB_DONE;
                     job.command = cmd_ff;
                     if (sum_ff != expect_sum) begin
                        fail = 1'b1;
                        priority if (cmd_ff == CMD_GET_PRESS) err = ERR_PRESSURE;
                        else if (cmd_ff == CMD_GET_GAS || cmd_ff == CMD_CAL_STAT ||
                                 cmd_ff == CMD_GET_HOURS) err = ERR_FAILED;
                        else err = ERR_CHECKSUM;
                     end else begin
                        job.ok = 1'b1;
                        unique case (cmd_ff)
                           CMD_GET_PRESS: begin
                              job.value = {16'd0, buf_ff[7], buf_ff[8]};
                              held_press_in = {buf_ff[7], buf_ff[8]};
                           end
                           CMD_GET_GAS: begin
                              if (buf_ff[11] != 8'd0) begin
                                 fail = 1'b1;
                                 err = ERR_GAS_STAT;
                              end else begin
                                 job.value = {buf_ff[7], buf_ff[8], buf_ff[9], buf_ff[10]};
                                 held_gas_in = {buf_ff[7], buf_ff[8], buf_ff[9], buf_ff[10]};
                              end
                           end
                           CMD_CAL_STAT: job.value = {24'd0, buf_ff[7]};
                           CMD_GET_HOURS: job.value = {16'd0, buf_ff[7], buf_ff[8]};
                           CMD_SET_HOURS: begin
                              job.value = {24'd0, buf_ff[7]};
                              job.ok = (buf_ff[7] == 8'd0);
                           end
                           default: job.value = '0;
                        endcase
                     end
                     if (fail) begin
                        job.ok = 1'b0;
                        job.error_code = err;
                        job.value = fail_value(cmd_ff, err, suppress_errors,
                                               held_press_ff, held_gas_ff);
                     end
                  end
               end
            end
            REQ_TICK: begin
               if (gas_age_ff != 16'hFFFF) gas_age_in = gas_age_ff + 16'd1;
               if (busy_ff) begin
                  if (wait_next > {1'b0, timeout_ticks}) begin
                     busy_in = 1'b0;
                     wait_in = '0;
                     err = (cmd_ff == CMD_GET_PRESS) ? ERR_PRESSURE : ERR_FAILED;
                     job_valid = 1'b1;
                     job.kind = JOB_DONE;
                     job.command = cmd_ff;
                     job.error_code = err;
                     job.value = fail_value(cmd_ff, err, suppress_errors,
                                            held_press_ff, held_gas_ff);
                  end else begin
                     wait_in = wait_next[15:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cmd_ff <= '0;
         cnt_ff <= '0;
         sum_ff <= '0;
         wait_ff <= '0;
         gas_age_ff <= '0;
         held_gas_ff <= '0;
         held_press_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cmd_ff <= cmd_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         wait_ff <= wait_in;
         gas_age_ff <= gas_age_in;
         held_gas_ff <= held_gas_in;
         held_press_ff <= held_press_in;
      end
   end

   // Response buffer: store the byte at the fill position while it fits.
   always_ff @(posedge clock) begin
      if (acc && req_type == REQ_RX && busy_ff && cnt_ff < 5'(MaxResponseBytes))
         buf_ff[BufIdxW'(cnt_ff)] <= req_rx_byte;
   end
endmodule

/* rtl/suce_queue.sv */
// Two-entry job queue between the front and back ends.
// Depends on suce_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sensor_uart_command_engine_top_defines.svh"
module suce_queue
   import suce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    not_empty,
   output job_type head,
   input  logic    pop
);
   job_type    slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

   `SUCE_ASSERT_IMPL(a_no_overflow, clock, reset, push, !full, "push into full queue")
   `SUCE_ASSERT_IMPL(a_no_underflow, clock, reset, pop, not_empty, "pop from empty queue")
   `SUCE_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3, "queue count broken")
endmodule

/* rtl/suce_back.sv */
// Back end: turns jobs into frame bytes or a completion result, with an output register.
// Depends on suce_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sensor_uart_command_engine_top_defines.svh"
module suce_back
   import suce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_ready,
   input  job_type     job,
   output logic        job_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_done_res,
   output logic        rsp_ok,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_error_code
);
   logic [3:0]  pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic        vld_ff;
   logic        load;
   logic [3:0]  nbytes;
   logic [7:0]  fbyte;
   logic        last;

   assign nbytes = 4'd9 + {2'd0, dlen_of(job.command)};
   assign load = job_ready && (!vld_ff || !rsp_stall);

   // Frame byte at the current position; checksum bytes come from the running sum.
   always_comb begin
      fbyte = 8'h00;
      if (pos_ff == nbytes - 4'd2) fbyte = sum_ff[15:8];
      else if (pos_ff == nbytes - 4'd1) fbyte = sum_ff[7:0];
      else begin
         unique case (pos_ff)
            4'd0: fbyte = 8'h42;
            4'd1: fbyte = 8'h4D;
            4'd2: fbyte = 8'hA0;
            4'd3: fbyte = 8'h00;
            4'd4: fbyte = opcode_of(job.command);
            4'd5: fbyte = 8'h00;
            4'd6: fbyte = {6'd0, dlen_of(job.command)};
            4'd7: begin
               if (dlen_of(job.command) == 2'd2) fbyte = job.argument[15:8];
               else fbyte = (job.command == CMD_CLOSE_CAL) ? 8'hFF : 8'h00;
            end
            4'd8: fbyte = job.argument[7:0];
            default: fbyte = 8'h00;
         endcase
      end
   end

   assign last = (job.kind != JOB_FRAME) || (pos_ff == nbytes - 4'd1);
   assign job_pop = load && last;

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (load && job.kind == JOB_FRAME) begin
         if (last) begin
            pos_in = '0;
            sum_in = '0;
         end else begin
            pos_in = pos_ff + 4'd1;
            // Hold the sum once the checksum bytes start going out.
            if (pos_ff < nbytes - 4'd2) sum_in = sum_ff + 16'(fbyte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         if (load) vld_ff <= 1'b1;
         else if (!rsp_stall) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (job.kind == JOB_FRAME) begin
            rsp_tx_valid <= 1'b1;
            rsp_tx_byte <= fbyte;
            rsp_done_res <= 1'b0;
            rsp_ok <= 1'b0;
            rsp_value <= '0;
            rsp_error_code <= ERR_NONE;
         end else begin
            rsp_tx_valid <= 1'b0;
            rsp_tx_byte <= '0;
            rsp_done_res <= 1'b1;
            rsp_ok <= job.ok;
            rsp_value <= job.value;
            rsp_error_code <= job.error_code;
         end
         rsp_last_of_run <= last;
      end
   end

   assign rsp_valid = vld_ff;

   `SUCE_ASSERT_IMPL(a_pos_range, clock, reset, 1'b1, pos_ff < 4'd11, "frame position out of range")
   `SUCE_ASSERT_NEXT(a_done_is_last, clock, reset, load && job.kind != JOB_FRAME,
      rsp_last_of_run && rsp_done_res, "completion not marked last")
   `SUCE_ASSERT_IMPL(a_pop_has_job, clock, reset, job_pop, job_ready, "pop without job")
endmodule

/* bench/tb_sensor_uart_command_engine_top.sv */
// Testbench for sensor_uart_command_engine_top: directed and random command traffic
// with a built-in predictor of frames and completions. Depends on suce_pkg and the RTL.
`timescale 1ns / 1ps
module tb_sensor_uart_command_engine_top;
   import suce_pkg::*;

   localparam int WatchdogLimit = 5000;
   localparam int DrainCycles   = 40;

   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  command;
      logic [15:0] argument;
      logic [7:0]  rx_byte;
   } cmd_item_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        last_of_run;
      logic        done_res;
      logic        ok;
      logic [31:0] value;
      logic [2:0]  error_code;
   } engine_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_TICK;
   logic [2:0]  req_command = CMD_GET_PRESS;
   logic [15:0] req_argument = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_of_run;
   logic        rsp_done_res;
   logic        rsp_ok;
   logic [31:0] rsp_value;
   logic [2:0]  rsp_error_code;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_TIMEOUT;
   logic [15:0] csr_data = '0;

   sensor_uart_command_engine_top DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Pending stimulus and the frames/completions we expect back.
   cmd_item_type      pending_items[$];
   engine_result_type expected_results[$];
   int                mismatches = 0;
   int                quiet_cycles = 0;
   logic              req_taken = 1'b0;
   // High during the stretch where neither side idles.
   logic              steady = 1'b0;

   // Predictor copy of configuration and engine state.
   logic [15:0] cfg_timeout;
   logic [15:0] cfg_interval;
   logic        cfg_suppress;
   logic        busy;
   logic [2:0]  act_cmd;
   logic [7:0]  reply_buf[0:15];
   logic [4:0]  reply_count;
   logic [15:0] reply_sum;
   logic [15:0] wait_count;
   logic [15:0] gas_age;
   logic [31:0] held_gas;
   logic [15:0] held_press;

   function automatic logic [4:0] reply_len(input logic [2:0] c);
      case (c)
         CMD_GET_GAS:                 return 5'd14;
         CMD_OPEN_CAL, CMD_CLOSE_CAL: return 5'd9;
         CMD_CAL_STAT, CMD_SET_HOURS: return 5'd10;
         default:                     return 5'd11;
      endcase
   endfunction

   function automatic logic [2:0] failure_code(input logic [2:0] c, input logic bad_sum);
      if (c == CMD_GET_PRESS) return ERR_PRESSURE;
      if (c == CMD_GET_GAS || c == CMD_CAL_STAT || c == CMD_GET_HOURS) return ERR_FAILED;
      return bad_sum ? ERR_CHECKSUM : ERR_FAILED;
   endfunction

   task automatic push_done(input logic ok, input logic [31:0] val, input logic [2:0] err);
      engine_result_type r;
      r = '{tx_valid: 1'b0, tx_byte: 8'h00, last_of_run: 1'b1, done_res: 1'b1,
            ok: ok, value: val, error_code: err};
      expected_results.push_back(r);
   endtask

   task automatic push_failure(input logic [2:0] c, input logic [2:0] err);
      logic [31:0] val;
      val = {29'd0, err};
      if (cfg_suppress) begin
         if (c == CMD_GET_PRESS) val = {16'd0, held_press};
         else if (c == CMD_GET_GAS) val = held_gas;
         else val = '0;
      end
      push_done(1'b0, val, err);
   endtask

   task automatic predict_start(input logic [2:0] c, input logic [15:0] arg);
      logic [7:0]  frame[0:11];
      logic [15:0] sum;
      int          n;
      engine_result_type r;
      sum = '0;
      n = 0;
      if (c == CMD_SET_PRESS && (arg < 700 || arg > 1100)) begin
         push_failure(c, ERR_ARGUMENT);
         return;
      end
      if (c == CMD_SET_HOURS && (arg < 24 || arg > 720)) begin
         push_failure(c, ERR_ARGUMENT);
         return;
      end
      if (c == CMD_GET_GAS) begin
         // Too soon after the last read: answer from the held level.
         if (gas_age < cfg_interval) begin
            push_done(1'b1, held_gas, ERR_NONE);
            return;
         end
         gas_age = '0;
      end
      frame[0] = 8'h42; frame[1] = 8'h4D; frame[2] = 8'hA0; frame[3] = 8'h00;
      case (c)
         CMD_GET_PRESS: frame[4] = 8'h02;
         CMD_SET_PRESS: frame[4] = 8'h01;
         CMD_GET_GAS:   frame[4] = 8'h03;
         CMD_CAL_STAT:  frame[4] = 8'h07;
         CMD_GET_HOURS: frame[4] = 8'h08;
         CMD_SET_HOURS: frame[4] = 8'h09;
         default:       frame[4] = 8'h06;
      endcase
      frame[5] = 8'h00;
      n = 7;
      if (c == CMD_SET_PRESS || c == CMD_SET_HOURS) begin
         frame[6] = 8'd2;
         frame[7] = arg[15:8];
         frame[8] = arg[7:0];
         n = 9;
      end else if (c == CMD_OPEN_CAL || c == CMD_CLOSE_CAL) begin
         frame[6] = 8'd1;
         frame[7] = (c == CMD_CLOSE_CAL) ? 8'hFF : 8'h00;
         n = 8;
      end else begin
         frame[6] = 8'd0;
      end
      for (int i = 0; i < n; i++) sum = sum + frame[i];
      frame[n] = sum[15:8];
      frame[n+1] = sum[7:0];
      n = n + 2;
      for (int i = 0; i < n; i++) begin
         r = '{tx_valid: 1'b1, tx_byte: frame[i], last_of_run: (i == n - 1),
               done_res: 1'b0, ok: 1'b0, value: '0, error_code: ERR_NONE};
         expected_results.push_back(r);
      end
      busy = 1'b1;
      act_cmd = c;
      reply_count = '0;
      reply_sum = '0;
      wait_count = '0;
   endtask

   task automatic predict_reply_end();
      logic [4:0]  n;
      logic [15:0] trailer;
      n = reply_len(act_cmd);
      trailer = {reply_buf[n-2], reply_buf[n-1]};
      busy = 1'b0;
      if (reply_sum != trailer) begin
         push_failure(act_cmd, failure_code(act_cmd, 1'b1));
         return;
      end
      case (act_cmd)
         CMD_GET_PRESS: begin
            held_press = {reply_buf[7], reply_buf[8]};
            push_done(1'b1, {16'd0, held_press}, ERR_NONE);
         end
         CMD_GET_GAS: begin
            if (reply_buf[11] != 8'h00) begin
               push_failure(act_cmd, ERR_GAS_STAT);
            end else begin
               held_gas = {reply_buf[7], reply_buf[8], reply_buf[9], reply_buf[10]};
               push_done(1'b1, held_gas, ERR_NONE);
            end
         end
         CMD_CAL_STAT:  push_done(1'b1, {24'd0, reply_buf[7]}, ERR_NONE);
         CMD_GET_HOURS: push_done(1'b1, {16'd0, reply_buf[7], reply_buf[8]}, ERR_NONE);
         CMD_SET_HOURS: push_done(reply_buf[7] == 8'h00, {24'd0, reply_buf[7]}, ERR_NONE);
         default:       push_done(1'b1, '0, ERR_NONE);
      endcase
   endtask

   // Advance the predictor by one accepted item.
   task automatic predict_item(input cmd_item_type it);
      if (it.kind == REQ_START) begin
         if (!busy) predict_start(it.command, it.argument);
      end else if (it.kind == REQ_RX) begin
         if (busy) begin
            if (reply_count < 16) reply_buf[reply_count[3:0]] = it.rx_byte;
            if (reply_count + 2 < reply_len(act_cmd)) reply_sum = reply_sum + it.rx_byte;
            reply_count = reply_count + 5'd1;
            if (reply_count >= reply_len(act_cmd)) predict_reply_end();
         end
      end else if (it.kind == REQ_TICK) begin
         if (gas_age != 16'hFFFF) gas_age = gas_age + 16'd1;
         if (busy) begin
            if ({1'b0, wait_count} + 17'd1 > {1'b0, cfg_timeout}) begin
               busy = 1'b0;
               wait_count = '0;
               push_failure(act_cmd, failure_code(act_cmd, 1'b0));
            end else begin
               wait_count = wait_count + 16'd1;
            end
         end
      end
   endtask

   // Monitor: sample both channels at the rising edge.
   always @(posedge clock) begin
      engine_result_type got, want;
      logic              rsp_taken;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            predict_item('{req_type, req_command, req_argument, req_rx_byte});
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            got = '{rsp_tx_valid, rsp_tx_byte, rsp_last_of_run, rsp_done_res,
                    rsp_ok, rsp_value, rsp_error_code};
            if (expected_results.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10) $display("mismatch: expected %p, got %p", want, got);
               end
            end
         end
         if (req_taken || rsp_taken) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Driver: change inputs at the falling edge; idle about 10% outside the steady stretch.
   always @(negedge clock) begin
      cmd_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled item
      end else if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 10)) begin
         it = pending_items.pop_front();
         req_valid <= 1'b1;
         req_type <= it.kind;
         req_command <= it.command;
         req_argument <= it.argument;
         req_rx_byte <= it.rx_byte;
      end else begin
         req_valid <= 1'b0;
      end
      rsp_stall <= !steady && ($urandom_range(99) < 10);
   end

   task automatic add_item(input logic [1:0] k, input logic [2:0] c,
                           input logic [15:0] arg, input logic [7:0] rx);
      pending_items.push_back('{k, c, arg, rx});
   endtask

   // Queue a reply of the right length for c; optionally spoil the trailer or gas status.
   task automatic add_reply(input logic [2:0] c, input logic bad_sum, input int ticks_pct);
      logic [7:0]  bytes[0:15];
      logic [15:0] sum;
      int          n;
      sum = '0;
      n = reply_len(c);
      for (int i = 0; i < n - 2; i++) begin
         bytes[i] = 8'($urandom_range(255));
         if (c == CMD_GET_GAS && i == 11 && $urandom_range(3) != 0) bytes[i] = 8'h00;
         if (c == CMD_SET_HOURS && i == 7 && $urandom_range(1) == 0) bytes[i] = 8'h00;
         sum = sum + bytes[i];
      end
      if (bad_sum) sum = sum ^ 16'(1 + $urandom_range(65534));
      bytes[n-2] = sum[15:8];
      bytes[n-1] = sum[7:0];
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < ticks_pct)
            add_item(REQ_TICK, 3'($urandom), 16'($urandom), 8'($urandom));
         add_item(REQ_RX, 3'($urandom), 16'($urandom), bytes[i]);
      end
   endtask

   // Wait until everything is drained and the engine has gone quiet.
   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_TIMEOUT) cfg_timeout = data;
      else if (idx == CSR_INTERVAL) cfg_interval = data;
      else if (idx == CSR_SUPPRESS) cfg_suppress = data[0];
   endtask

   task automatic random_phase(input int min_items);
      int          start_size;
      int          added;
      logic [2:0]  c;
      logic [15:0] arg;
      added = 0;
      while (added < min_items) begin
         start_size = pending_items.size();
         if ($urandom_range(99) < 15) begin
            // noise: any type, any field
            add_item(2'($urandom), 3'($urandom), 16'($urandom), 8'($urandom));
         end else begin
            c = 3'($urandom);
            arg = 16'($urandom);
            if (c == CMD_SET_PRESS && $urandom_range(3) != 0)
               arg = 16'(700 + $urandom_range(400));
            if (c == CMD_SET_HOURS && $urandom_range(3) != 0)
               arg = 16'(24 + $urandom_range(696));
            add_item(REQ_START, c, arg, 8'($urandom));
            for (int i = $urandom_range(3); i > 0; i--)
               add_item(REQ_TICK, 3'($urandom), 16'($urandom), 8'($urandom));
            if ($urandom_range(9) != 0) add_reply(c, $urandom_range(99) < 15, 8);
            else add_item(REQ_START, 3'($urandom), 16'($urandom), 8'($urandom));
         end
         added += pending_items.size() - start_size;
      end
      wait_idle();
   endtask

   initial begin
      cfg_timeout = 16'd100;
      cfg_interval = 16'd2000;
      cfg_suppress = 1'b0;
      busy = 1'b0;
      act_cmd = CMD_GET_PRESS;
      reply_count = '0;
      reply_sum = '0;
      wait_count = '0;
      gas_age = '0;
      held_gas = '0;
      held_press = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: early gas read, argument limits, idle noise, busy start, timeout.
      write_reg(CSR_TIMEOUT, 16'd1);
      add_item(REQ_START, CMD_GET_GAS, 16'd0, 8'd0);
      add_item(REQ_START, CMD_SET_PRESS, 16'd699, 8'd0);
      add_item(REQ_START, CMD_SET_PRESS, 16'd1101, 8'd0);
      add_item(REQ_START, CMD_SET_HOURS, 16'd23, 8'd0);
      add_item(REQ_START, CMD_SET_HOURS, 16'd721, 8'd0);
      add_item(REQ_START, CMD_SET_HOURS, 16'hFFFF, 8'd0);
      add_item(REQ_RX, CMD_GET_PRESS, 16'd0, 8'hFF);
      add_item(2'd3, 3'd7, 16'hFFFF, 8'hFF);
      add_item(REQ_START, CMD_CLOSE_CAL, 16'd0, 8'd0);
      add_item(REQ_START, CMD_GET_HOURS, 16'hFFFF, 8'd0);
      add_item(REQ_TICK, CMD_GET_PRESS, 16'd0, 8'd0);
      add_item(REQ_TICK, CMD_GET_PRESS, 16'd0, 8'd0);
      add_item(REQ_START, CMD_SET_PRESS, 16'd1100, 8'd0);
      add_reply(CMD_SET_PRESS, 1'b1, 0);
      wait_idle();

      // Random phases over several settings, extremes included.
      write_reg(CSR_TIMEOUT, 16'd100);
      random_phase(30);
      write_reg(CSR_INTERVAL, 16'd0);
      write_reg(CSR_SUPPRESS, 16'd1);
      random_phase(30);
      write_reg(CSR_TIMEOUT, 16'd65535);
      write_reg(CSR_SUPPRESS, 16'd0);
      // No idling on either side through this whole phase.
      steady = 1'b1;
      random_phase(30);
      steady = 1'b0;
      write_reg(CSR_TIMEOUT, 16'd3);
      write_reg(CSR_INTERVAL, 16'd5);
      write_reg(CSR_SUPPRESS, 16'd1);
      random_phase(30);
      write_reg(CSR_TIMEOUT, 16'd2);
      write_reg(CSR_INTERVAL, 16'd65535);
      write_reg(CSR_SUPPRESS, 16'd0);
      random_phase(30);

      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/suce_pkg.sv
rtl/suce_front.sv
rtl/suce_queue.sv
rtl/suce_back.sv
rtl/sensor_uart_command_engine_top.sv
bench/tb_sensor_uart_command_engine_top.sv
